// ===== src/sme_pkg.sv =====
// Package for the stable matching engine: payload structs and request codes.
// No dependencies.
`default_nettype none
package sme_pkg;
    typedef enum logic [1:0] {
        REQ_LOAD_PREF = 2'd0,
        REQ_LOAD_RANK = 2'd1,
        REQ_RUN       = 2'd2,
        REQ_NONE      = 2'd3
    } req_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [4:0] person;
        logic [4:0] rank_pos;
        logic [4:0] partner;
    } in_item_t;

    typedef struct packed {
        logic [4:0] proposer;
        logic [4:0] acceptor;
        logic       matched;
        logic       last;
    } out_item_t;
endpackage
`default_nettype wire

// ===== src/sme_ram.sv =====
// Generic single-port-write, single-read synchronous RAM, registered read.
// No dependencies.
`default_nettype none
module sme_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== src/stable_matching_engine_unit.sv =====
// Top level of the stable matching engine.
// Depends on sme_pkg and sme_ram.
//
// Usage: in channel carries load and run transactions (in_item_t), out
// channel carries one result per proposer (out_item_t). cfg_we/cfg_data
// write pair_count; the user must do so only while idle (not enforced).
// Loads are taken one per cycle back to back while idle, no result.
// A run is accepted, clears the small tables, then walks proposals: list
// end S_PREF; choice beyond n S_PREF, S_ACC; free acceptor S_PREF, S_ACC,
// S_RNEW; rejected proposal adds S_RCUR; displacement adds S_NC
// (next-choice reload). Each result passes S_ORD (proposer partner read)
// and S_OUT (output register load); in_ready stays low from the run's
// acceptance until the last result is loaded into the output register.
// Preference and rank tables live in two large RAMs; partner and
// next-choice tables are small registered-read RAMs cleared at run start.
// Reset returns the control to idle, clears out_valid and sets pair_count
// to 32; the large tables are undefined until loaded. A stalled receiver
// holds the result register and the sequencer waits in its output state.
`default_nettype none
module stable_matching_engine_unit #(
    parameter int MAX_PAIRS = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire sme_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output sme_pkg::out_item_t      out_data,
    input  wire logic               cfg_we,
    input  wire logic [5:0]         cfg_data
);
    import sme_pkg::*;

    // indexes are five bits wide, so at most 32 pairs take part in a run
    localparam int LIM = (MAX_PAIRS < 32) ? MAX_PAIRS : 32;
    localparam int PW  = $clog2(LIM);
    localparam int AW  = 2 * PW;
    localparam int CW  = PW + 1;
    // partner entries: top bit set = unmatched
    localparam logic [PW:0] NONE_MARK = {1'b1, {PW{1'b0}}};

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CLR   = 9'b000000010,
        S_NC    = 9'b000000100,
        S_PREF  = 9'b000001000,
        S_ACC   = 9'b000010000,
        S_RNEW  = 9'b000100000,
        S_RCUR  = 9'b001000000,
        S_ORD   = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t         state_reg, state_next;
    logic [5:0]     pc_reg;
    logic [CW-1:0]  n_eff;
    logic [CW-1:0]  ctr_reg, ctr_next, ctr_inc;
    logic           ctr_last;
    logic [PW-1:0]  suitor_reg, suitor_next;
    logic [CW-1:0]  choice_reg, choice_next;
    logic [PW-1:0]  acc_reg, acc_next;
    logic [PW-1:0]  cur_reg, cur_next;
    logic [4:0]     rnew_reg, rnew_next;
    logic           ovalid_reg;
    out_item_t      odata_reg;
    logic           out_free;
    logic           in_ok;

    // small RAM ports
    logic           ap_we, pp_we, nc_we;
    logic [PW-1:0]  ap_wa, pp_wa, nc_wa, ap_ra, pp_ra, nc_ra;
    logic [PW:0]    ap_wd, pp_wd, ap_rd, pp_rd;
    logic [CW-1:0]  nc_wd, nc_rd;
    // big RAM ports
    logic           pf_we, rk_we;
    logic [AW-1:0]  pf_wa, rk_wa, pf_ra, rk_ra;
    logic [4:0]     pf_rd, rk_rd;

    assign in_ok = (7'(in_data.person) < 7'(MAX_PAIRS))
                && (7'(in_data.rank_pos) < 7'(MAX_PAIRS))
                && (7'(in_data.partner) < 7'(MAX_PAIRS));

    // effective pair count, saturated to 1..min(32, MAX_PAIRS)
    always_comb
    begin
        logic [6:0] n7;
        n7 = {1'b0, pc_reg};
        if (n7 == 7'd0) n7 = 7'd1;
        if (n7 > 7'(LIM)) n7 = 7'(LIM);
        n_eff = CW'(n7);
    end

    assign ctr_inc  = ctr_reg + 1'b1;
    assign ctr_last = (ctr_inc == n_eff);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;
    assign out_free  = !ovalid_reg || out_ready;

    sme_ram #(.WIDTH(5), .DEPTH(1 << AW)) u_pref (
        .clk(clk), .we(pf_we), .waddr(pf_wa), .wdata(in_data.partner),
        .raddr(pf_ra), .rdata(pf_rd));
    sme_ram #(.WIDTH(5), .DEPTH(1 << AW)) u_rank (
        .clk(clk), .we(rk_we), .waddr(rk_wa), .wdata(in_data.rank_pos),
        .raddr(rk_ra), .rdata(rk_rd));
    sme_ram #(.WIDTH(PW + 1), .DEPTH(1 << PW)) u_accp (
        .clk(clk), .we(ap_we), .waddr(ap_wa), .wdata(ap_wd),
        .raddr(ap_ra), .rdata(ap_rd));
    sme_ram #(.WIDTH(PW + 1), .DEPTH(1 << PW)) u_prop (
        .clk(clk), .we(pp_we), .waddr(pp_wa), .wdata(pp_wd),
        .raddr(pp_ra), .rdata(pp_rd));
    sme_ram #(.WIDTH(CW), .DEPTH(1 << PW)) u_next (
        .clk(clk), .we(nc_we), .waddr(nc_wa), .wdata(nc_wd),
        .raddr(nc_ra), .rdata(nc_rd));

    // The active suitor's next choice lives in choice_reg; the next-choice
    // table is cleared at run start, written when he engages, read back
    // when he is displaced, so a read never meets a write to the same entry.
    always_comb
    begin
        state_next  = state_reg;
        ctr_next    = ctr_reg;
        suitor_next = suitor_reg;
        choice_next = choice_reg;
        acc_next    = acc_reg;
        cur_next    = cur_reg;
        rnew_next   = rnew_reg;
        pf_we = 1'b0; rk_we = 1'b0; ap_we = 1'b0; pp_we = 1'b0; nc_we = 1'b0;
        pf_wa = {in_data.person[PW-1:0], in_data.rank_pos[PW-1:0]};
        rk_wa = {in_data.person[PW-1:0], in_data.partner[PW-1:0]};
        pf_ra = {suitor_reg, choice_reg[PW-1:0]};
        rk_ra = {PW'(pf_rd), suitor_reg};
        ap_wa = acc_reg;    ap_wd = {1'b0, suitor_reg};
        pp_wa = suitor_reg; pp_wd = {1'b0, acc_reg};
        nc_wa = suitor_reg; nc_wd = choice_reg;
        ap_ra = PW'(pf_rd);
        pp_ra = ctr_reg[PW-1:0];
        nc_ra = cur_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (req_t'(in_data.req_type))
                        REQ_LOAD_PREF: pf_we = in_ok;
                        REQ_LOAD_RANK: rk_we = in_ok;
                        REQ_RUN:
                        begin
                            ctr_next   = '0;
                            state_next = S_CLR;
                        end
                        REQ_NONE: ;
                    endcase
                end
            end
            S_CLR:
            begin
                ap_we = 1'b1; pp_we = 1'b1; nc_we = 1'b1;
                ap_wa = ctr_reg[PW-1:0]; pp_wa = ctr_reg[PW-1:0];
                nc_wa = ctr_reg[PW-1:0];
                ap_wd = NONE_MARK; pp_wd = NONE_MARK; nc_wd = '0;
                if (ctr_last)
                begin
                    ctr_next    = '0;
                    suitor_next = '0;
                    choice_next = '0;
                    state_next  = S_PREF;
                end
                else
                begin
                    ctr_next = ctr_inc;
                end
            end
            S_NC:
            begin
                // displaced proposer resumes at his stored next choice
                choice_next = nc_rd;
                state_next  = S_PREF;
            end
            S_PREF:
            begin
                if (choice_reg >= n_eff)
                begin
                    // list exhausted: suitor stays unmatched
                    pp_we = 1'b1; pp_wd = NONE_MARK;
                    if (ctr_last)
                    begin
                        ctr_next   = '0;
                        state_next = S_ORD;
                    end
                    else
                    begin
                        ctr_next    = ctr_inc;
                        suitor_next = PW'(ctr_inc);
                        choice_next = '0;
                        state_next  = S_PREF;
                    end
                end
                else
                begin
                    choice_next = choice_reg + 1'b1;
                    state_next  = S_ACC;
                end
            end
            S_ACC:
            begin
                // pf_rd = chosen acceptor; skipped if at or past the pair count
                if ({1'b0, pf_rd} >= 6'(n_eff))
                begin
                    state_next = S_PREF;
                end
                else
                begin
                    acc_next   = PW'(pf_rd);
                    state_next = S_RNEW;
                end
            end
            S_RNEW:
            begin
                if (ap_rd[PW])
                begin
                    // free acceptor: engage, next outer proposer
                    ap_we = 1'b1; pp_we = 1'b1; nc_we = 1'b1;
                    if (ctr_last)
                    begin
                        ctr_next   = '0;
                        state_next = S_ORD;
                    end
                    else
                    begin
                        ctr_next    = ctr_inc;
                        suitor_next = PW'(ctr_inc);
                        choice_next = '0;
                        state_next  = S_PREF;
                    end
                end
                else
                begin
                    rnew_next  = rk_rd;
                    cur_next   = ap_rd[PW-1:0];
                    rk_ra      = {acc_reg, ap_rd[PW-1:0]};
                    state_next = S_RCUR;
                end
            end
            S_RCUR:
            begin
                if (rnew_reg < rk_rd)
                begin
                    // strictly better: take over, holder resumes proposing
                    ap_we = 1'b1; pp_we = 1'b1; nc_we = 1'b1;
                    suitor_next = cur_reg;
                    state_next  = S_NC;
                end
                else
                begin
                    // equal or worse rank: holder kept
                    state_next = S_PREF;
                end
            end
            S_ORD:
            begin
                // pp_rd for ctr_reg arrives next cycle
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    if (ctr_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ctr_next   = ctr_inc;
                        state_next = S_ORD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pc_reg     <= 6'd32;
            ovalid_reg <= 1'b0;
            ctr_reg    <= '0;
            suitor_reg <= '0;
            choice_reg <= '0;
            acc_reg    <= '0;
            cur_reg    <= '0;
            rnew_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ctr_reg    <= ctr_next;
            suitor_reg <= suitor_next;
            choice_reg <= choice_next;
            acc_reg    <= acc_next;
            cur_reg    <= cur_next;
            rnew_reg   <= rnew_next;
            if (cfg_we) pc_reg <= cfg_data;
            if (state_reg == S_OUT && out_free) ovalid_reg <= 1'b1;
            else if (out_ready) ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && out_free)
        begin
            odata_reg.proposer <= 5'(ctr_reg);
            odata_reg.matched  <= !pp_rd[PW];
            odata_reg.acceptor <= pp_rd[PW] ? 5'd0 : 5'(pp_rd[PW-1:0]);
            odata_reg.last     <= ctr_last;
        end
    end
endmodule
`default_nettype wire
